// ----- src/bdd_pkg.sv -----
// ----------------------------------------------------------------------------
// bdd_pkg: shared types for the bounded deque
// Operation codes, result status codes, command struct and engine states.
// ----------------------------------------------------------------------------
package bdd_pkg;

   localparam int ValueWidth  = 32;
   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 3;

   // Operation carried by one request beat
   typedef enum logic [ModeWidth-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_DELETE     = 2'd2,
      OP_READ       = 2'd3
   } op_type;

   // Result status
   typedef enum logic [StatusWidth-1:0] {
      ST_DONE       = 3'd0,
      ST_EMPTY_DEL  = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_FULL       = 3'd3,
      ST_ELEMENT    = 3'd4,
      ST_LIST_EMPTY = 3'd5
   } status_type;

   // Classified command handed from front to back
   typedef struct packed {
      op_type                 op;
      logic [ValueWidth-1:0]  value;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SEARCH = 2'd1,
      S_WALK   = 2'd2
   } state_type;

endpackage

// ----- src/bdd_req_if.sv -----
// ----------------------------------------------------------------------------
// bdd_req_if: request channel
// Valid/ready channel carrying one deque operation per beat.
// ----------------------------------------------------------------------------
interface bdd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [bdd_pkg::ModeWidth-1:0]         mode;
   logic signed [bdd_pkg::ValueWidth-1:0] item_value;

   modport source (output valid, output mode, output item_value, input ready);
   modport sink   (input valid, input mode, input item_value, output ready);
endinterface

// ----- src/bdd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bdd_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface bdd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [bdd_pkg::StatusWidth-1:0]       status;
   logic signed [bdd_pkg::ValueWidth-1:0] out_value;
   logic                                  last;

   modport source (output valid, output status, output out_value, output last,
                   input ready);
   modport sink   (input valid, input status, input out_value, input last,
                   output ready);
endinterface

// ----- src/bdd_ram.sv -----
// ----------------------------------------------------------------------------
// bdd_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bdd_front.sv -----
// ----------------------------------------------------------------------------
// bdd_front: request intake
// Accepts request beats, decodes the mode and buffers commands in a
// two-entry queue so the intake runs ahead of the back end.
// ----------------------------------------------------------------------------
module bdd_front (
   input  logic              clock,
   input  logic              reset,
   bdd_req_if.sink           req_bus,
   output logic              cmd_valid,
   output bdd_pkg::cmd_type  cmd,
   input  logic              cmd_ready
);

   bdd_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   bdd_pkg::cmd_type decoded;
   logic             push, pop;

   // decode the mode field; every 2-bit mode is a valid operation
   always_comb begin
      decoded.value = req_bus.item_value;
      decoded.op    = bdd_pkg::op_type'(req_bus.mode);
   end

   assign req_bus.ready = (cnt_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (cnt_ff != 2'd0);
   assign pop           = cmd_valid && cmd_ready;
   assign cmd           = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- src/bdd_back.sv -----
// ----------------------------------------------------------------------------
// bdd_back: list engine
// Executes one command at a time on the linked slot store: pushes as the
// command is taken; delete searches, and list reads while the output is free,
// walk the links one slot a cycle. Holds the response output register.
// ----------------------------------------------------------------------------
module bdd_back #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bdd_pkg::cmd_type  cmd,
   output logic              cmd_ready,
   bdd_rsp_if.source         rsp_bus
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = bdd_pkg::ValueWidth;

   bdd_pkg::state_type  state_ff, state_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       first_ff, first_in;
   logic [SW-1:0]       last_ff, last_in;
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [VW-1:0]       val_ff, val_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   bdd_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [VW-1:0]          rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_load;

   logic          val_we, next_we, prev_we;
   logic [SW-1:0] val_waddr, next_waddr, prev_waddr, raddr;
   logic [VW-1:0] val_wdata, val_rdata;
   logic [SW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;

   logic          out_free, take, at_end, match;
   logic [SW-1:0] free_slot;

   // slot store: values and links
   bdd_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(raddr), .rd_data(val_rdata));
   bdd_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_waddr), .wr_data(next_wdata),
      .rd_addr(raddr), .rd_data(next_rdata));
   bdd_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_waddr), .wr_data(prev_wdata),
      .rd_addr(raddr), .rd_data(prev_rdata));

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign take      = (state_ff == bdd_pkg::S_IDLE) && cmd_valid && out_free;
   assign cmd_ready = (state_ff == bdd_pkg::S_IDLE) && out_free;
   assign at_end    = ((steps_ff + CW'(1)) == count_ff);
   assign match     = (val_rdata == val_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdd_pkg::S_IDLE: begin
            if (take && count_ff != '0) begin
               if (cmd.op == bdd_pkg::OP_DELETE) begin
                  state_in = bdd_pkg::S_SEARCH;
               end else if (cmd.op == bdd_pkg::OP_READ) begin
                  state_in = bdd_pkg::S_WALK;
               end
            end
         end
         bdd_pkg::S_SEARCH: begin
            if (match || at_end) begin
               state_in = bdd_pkg::S_IDLE;
            end
         end
         bdd_pkg::S_WALK: begin
            if (out_free && at_end) begin
               state_in = bdd_pkg::S_IDLE;
            end
         end
         default: state_in = bdd_pkg::S_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      count_in      = count_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      used_in       = used_ff;
      val_in        = val_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = 1'b1;
      val_we        = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      val_waddr     = free_slot;
      val_wdata     = cmd.value;
      next_waddr    = free_slot;
      next_wdata    = first_ff;
      prev_waddr    = first_ff;
      prev_wdata    = free_slot;
      raddr         = cur_ff;
      case (state_ff)
         bdd_pkg::S_IDLE: begin
            raddr = first_ff;
            if (take) begin
               val_in       = cmd.value;
               rsp_value_in = cmd.value;
               case (cmd.op)
                  bdd_pkg::OP_PUSH_FRONT, bdd_pkg::OP_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_status_in = bdd_pkg::ST_FULL;
                     end else begin
                        rsp_status_in        = bdd_pkg::ST_DONE;
                        val_we               = 1'b1;
                        used_in[free_slot]   = 1'b1;
                        count_in             = count_ff + CW'(1);
                        if (count_ff == '0) begin
                           first_in = free_slot;
                           last_in  = free_slot;
                        end else if (cmd.op == bdd_pkg::OP_PUSH_FRONT) begin
                           // new head links forward to old head
                           next_we    = 1'b1;
                           next_waddr = free_slot;
                           next_wdata = first_ff;
                           prev_we    = 1'b1;
                           prev_waddr = first_ff;
                           prev_wdata = free_slot;
                           first_in   = free_slot;
                        end else begin
                           // new tail links back to old tail
                           prev_we    = 1'b1;
                           prev_waddr = free_slot;
                           prev_wdata = last_ff;
                           next_we    = 1'b1;
                           next_waddr = last_ff;
                           next_wdata = free_slot;
                           last_in    = free_slot;
                        end
                     end
                  end
                  bdd_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = bdd_pkg::ST_EMPTY_DEL;
                     end else begin
                        cur_in   = first_ff;
                        steps_in = '0;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = bdd_pkg::ST_LIST_EMPTY;
                        rsp_value_in  = '0;
                     end else begin
                        cur_in   = first_ff;
                        steps_in = '0;
                     end
                  end
               endcase
            end
         end
         bdd_pkg::S_SEARCH: begin
            rsp_value_in = val_ff;
            if (match) begin
               // unlink slot cur_ff
               rsp_load      = 1'b1;
               rsp_status_in = bdd_pkg::ST_DONE;
               used_in[cur_ff] = 1'b0;
               count_in      = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  first_in = '0;
                  last_in  = '0;
               end else if (cur_ff == first_ff) begin
                  first_in   = next_rdata;
                  prev_we    = 1'b1;
                  prev_waddr = next_rdata;
                  prev_wdata = '0;
               end else if (cur_ff == last_ff) begin
                  last_in    = prev_rdata;
                  next_we    = 1'b1;
                  next_waddr = prev_rdata;
                  next_wdata = '0;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = prev_rdata;
                  next_wdata = next_rdata;
                  prev_we    = 1'b1;
                  prev_waddr = next_rdata;
                  prev_wdata = prev_rdata;
               end
            end else if (at_end) begin
               rsp_load      = 1'b1;
               rsp_status_in = bdd_pkg::ST_NOT_FOUND;
            end else begin
               cur_in   = next_rdata;
               raddr    = next_rdata;
               steps_in = steps_ff + CW'(1);
            end
         end
         bdd_pkg::S_WALK: begin
            // hold the read address while the output stalls
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = bdd_pkg::ST_ELEMENT;
               rsp_value_in  = val_rdata;
               rsp_last_in   = at_end;
               cur_in        = next_rdata;
               raddr         = next_rdata;
               steps_in      = steps_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // response valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdd_pkg::S_IDLE;
         count_ff     <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      val_ff   <= val_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule

// ----- src/bounded_deque_with_delete.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_delete: bounded deque with delete by value
// Ordered list of up to CAPACITY signed 32-bit values in a linked slot store.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one operation per beat: mode 0 push front, 1 push back,
//   2 delete first entry equal to item_value, 3 read the whole list.
//   rsp_bus returns result beats; last marks the final beat of an operation.
//   Push and delete give one beat echoing item_value; read gives one beat per
//   entry front to back, or a single list-empty beat when nothing is stored.
// Timing:
//   A two-entry command queue takes request beats while the engine works.
//   Push: result appears in the cycle after the engine takes the command.
//   Delete: the search visits slots front to back, at most every stored entry.
//   Read: one beat per entry, one beat per cycle while the response is not held.
//   The engine runs one command at a time; the link walk through the slot
//   RAM, one read per cycle, sets the delete and read durations.
// Reset: synchronous; the list is emptied at once, no clearing pass.
// Stall: a held response beat stops the engine; requests queue until full.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   bdd_req_if.sink   req_bus,
   bdd_rsp_if.source rsp_bus
);

   logic             cmd_valid;
   logic             cmd_ready;
   bdd_pkg::cmd_type cmd;

   bdd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   bdd_back #(.CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_deque_with_delete
// Drives deque operations (push front/back, delete by value, read list)
// through the request channel under random stalls on both sides. A queue
// model of the list predicts every result beat, and each returned beat is
// checked in order against it.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAPACITY    = 16;
   localparam int HOLD_CYCLES = 250;   // long response stall, fills the input
   localparam int DRAIN_WAIT  = 40;    // > longest delete or read walk
   localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side

   typedef struct {
      bdd_pkg::op_type        op;
      logic signed [31:0]     value;
   } deque_req_type;

   typedef struct {
      bdd_pkg::status_type    status;
      logic signed [31:0]     value;
      logic                   last;
   } result_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdd_req_if req_bus ();
   bdd_rsp_if rsp_bus ();

   bounded_deque_with_delete #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Stimulus and scoreboard state
   deque_req_type      pending_reqs[$];
   result_beat_type    expected_beats[$];
   logic signed [31:0] list_model[$];

   int  items_queued  = 0;
   int  req_beats     = 0;
   int  rsp_beats     = 0;
   int  error_count   = 0;
   int  idle_cycles   = 0;
   int  send_idle_pct = 31;
   int  recv_idle_pct = 82;
   int  phase_no      = 0;
   int  phase_base    = 0;
   int  hold_left     = 0;
   bit  hold_used     = 1'b0;
   bit  req_taken     = 1'b0;
   int  op_hits[4];
   int  status_hits[6];

   // 4-unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic result_beat_type make_beat(bdd_pkg::status_type st,
                                                 logic signed [31:0] v,
                                                 logic l);
      result_beat_type b;
      b.status = st;
      b.value  = v;
      b.last   = l;
      status_hits[st] = status_hits[st] + 1;
      return b;
   endfunction

   // Apply one operation to the list model and queue the beats it yields
   task automatic predict_deque_op(input bdd_pkg::op_type op,
                                   input logic signed [31:0] v);
      int hit;
      hit = -1;
      op_hits[op] = op_hits[op] + 1;
      case (op)
         bdd_pkg::OP_PUSH_FRONT, bdd_pkg::OP_PUSH_BACK: begin
            if (list_model.size() >= CAPACITY) begin
               expected_beats.push_back(make_beat(bdd_pkg::ST_FULL, v, 1'b1));
            end else begin
               if (op == bdd_pkg::OP_PUSH_FRONT) list_model.push_front(v);
               else                              list_model.push_back(v);
               expected_beats.push_back(make_beat(bdd_pkg::ST_DONE, v, 1'b1));
            end
         end
         bdd_pkg::OP_DELETE: begin
            if (list_model.size() == 0) begin
               expected_beats.push_back(make_beat(bdd_pkg::ST_EMPTY_DEL, v, 1'b1));
            end else begin
               // first match seen from the front
               for (int i = 0; i < list_model.size(); i++) begin
                  if (hit < 0 && list_model[i] == v) hit = i;
               end
               if (hit < 0) begin
                  expected_beats.push_back(make_beat(bdd_pkg::ST_NOT_FOUND, v, 1'b1));
               end else begin
                  list_model.delete(hit);
                  expected_beats.push_back(make_beat(bdd_pkg::ST_DONE, v, 1'b1));
               end
            end
         end
         default: begin
            if (list_model.size() == 0) begin
               expected_beats.push_back(make_beat(bdd_pkg::ST_LIST_EMPTY, '0, 1'b1));
            end else begin
               foreach (list_model[i]) begin
                  expected_beats.push_back(make_beat(bdd_pkg::ST_ELEMENT, list_model[i],
                                                     i == list_model.size() - 1));
               end
            end
         end
      endcase
   endtask

   task automatic queue_req(input bdd_pkg::op_type op, input logic signed [31:0] v);
      deque_req_type r;
      r.op    = op;
      r.value = v;
      pending_reqs.push_back(r);
      items_queued++;
   endtask

   // Mostly a small value pool so deletes hit and duplicates occur
   function automatic logic signed [31:0] pick_value(int pool_pct);
      if ($urandom_range(99) < pool_pct) return $urandom_range(7) - 3;
      return $urandom;
   endfunction

   // Random traffic in fill and drain stretches so the list swings
   // between empty and full
   task automatic queue_random_ops(input int count);
      int  left;
      int  seg_len;
      int  roll;
      bit  filling;
      left    = count;
      filling = 1'b1;
      while (left > 0) begin
         seg_len = $urandom_range(30, 10);
         if (seg_len > left) seg_len = left;
         for (int i = 0; i < seg_len; i++) begin
            roll = $urandom_range(99);
            if (filling) begin
               if      (roll < 40) queue_req(bdd_pkg::OP_PUSH_FRONT, pick_value(70));
               else if (roll < 75) queue_req(bdd_pkg::OP_PUSH_BACK,  pick_value(70));
               else if (roll < 85) queue_req(bdd_pkg::OP_DELETE,     pick_value(80));
               else                queue_req(bdd_pkg::OP_READ,       pick_value(0));
            end else begin
               if      (roll < 10) queue_req(bdd_pkg::OP_PUSH_FRONT, pick_value(70));
               else if (roll < 20) queue_req(bdd_pkg::OP_PUSH_BACK,  pick_value(70));
               else if (roll < 80) queue_req(bdd_pkg::OP_DELETE,     pick_value(85));
               else                queue_req(bdd_pkg::OP_READ,       pick_value(0));
            end
         end
         left    = left - seg_len;
         filling = !filling;
      end
   endtask

   task automatic wait_all_accepted();
      while (req_beats < items_queued) @(negedge clock);
   endtask

   // Request driver: a new beat is offered once the previous one is taken
   always @(negedge clock) begin : drive_req
      deque_req_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.mode       <= next_req.op;
            req_bus.item_value <= next_req.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus one long hold in the last phase
   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (!hold_used && phase_no == 2 && req_beats >= phase_base + 8) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on request beats, check result beats, watch for hangs
   always @(posedge clock) begin : monitor
      result_beat_type want;
      bit              rsp_taken;
      if (reset) begin
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         rsp_taken = rsp_bus.valid && rsp_bus.ready;
         if (req_taken) begin
            req_beats++;
            predict_deque_op(bdd_pkg::op_type'(req_bus.mode), req_bus.item_value);
         end
         if (rsp_taken) begin
            rsp_beats++;
            if (expected_beats.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result beat, expected none, %s %0d %0d %0b",
                        $time, "got status/value/last", rsp_bus.status,
                        rsp_bus.out_value, rsp_bus.last);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_bus.status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d (%s), got %0d",
                           $time, want.status, want.status.name(), rsp_bus.status);
               end
               if (rsp_bus.out_value !== want.value) begin
                  error_count++;
                  $display("%0t: out_value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_bus.out_value);
               end
               if (rsp_bus.last !== want.last) begin
                  error_count++;
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_bus.last);
               end
            end
         end
         if (req_taken || rsp_taken) idle_cycles = 0;
         else                         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_beats.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // Test sequence
   initial begin : stimulus
      req_bus.valid      = 1'b0;
      req_bus.mode       = bdd_pkg::OP_READ;
      req_bus.item_value = '0;
      rsp_bus.ready      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty list cases, extreme values, duplicates, deletes at
      // front, middle and back, delete of the only entry
      queue_req(bdd_pkg::OP_READ,       32'sd0);
      queue_req(bdd_pkg::OP_DELETE,     32'sd5);
      queue_req(bdd_pkg::OP_PUSH_BACK,  32'sh8000_0000);
      queue_req(bdd_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
      queue_req(bdd_pkg::OP_PUSH_BACK,  -32'sd1);
      queue_req(bdd_pkg::OP_PUSH_FRONT, 32'sd0);
      queue_req(bdd_pkg::OP_PUSH_BACK,  32'sd0);
      queue_req(bdd_pkg::OP_READ,       32'shffff_ffff);
      queue_req(bdd_pkg::OP_DELETE,     32'sh55aa_55aa);
      queue_req(bdd_pkg::OP_DELETE,     32'sd0);
      queue_req(bdd_pkg::OP_DELETE,     32'sh8000_0000);
      queue_req(bdd_pkg::OP_DELETE,     32'sd0);
      queue_req(bdd_pkg::OP_READ,       32'sd0);
      queue_req(bdd_pkg::OP_DELETE,     32'sh7fff_ffff);
      queue_req(bdd_pkg::OP_READ,       32'sd0);
      queue_req(bdd_pkg::OP_DELETE,     -32'sd1);
      queue_req(bdd_pkg::OP_READ,       32'sd0);
      queue_req(bdd_pkg::OP_DELETE,     -32'sd1);

      // Phase 0: sender idles lightly, receiver heavily
      queue_random_ops(114);
      wait_all_accepted();

      // Phase 1: roles swapped
      send_idle_pct = 82;
      recv_idle_pct = 31;
      phase_no      = 1;
      phase_base    = req_beats;
      queue_random_ops(138);
      wait_all_accepted();

      // Phase 2: full rate, with one long response hold
      send_idle_pct = 0;
      recv_idle_pct = 0;
      phase_base    = req_beats;
      phase_no      = 2;
      queue_random_ops(140);
      wait_all_accepted();

      while (expected_beats.size() > 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("Ran %0d request beats (%0d push front, %0d push back, %0d delete, %0d read),",
               req_beats, op_hits[bdd_pkg::OP_PUSH_FRONT], op_hits[bdd_pkg::OP_PUSH_BACK],
               op_hits[bdd_pkg::OP_DELETE], op_hits[bdd_pkg::OP_READ]);
      $display("%0d result beats checked: %0d full drops, %0d deletes on empty, %0d misses, %s",
               rsp_beats, status_hits[bdd_pkg::ST_FULL], status_hits[bdd_pkg::ST_EMPTY_DEL],
               status_hits[bdd_pkg::ST_NOT_FOUND],
               $sformatf("%0d empty reads, %0d elements.",
                         status_hits[bdd_pkg::ST_LIST_EMPTY],
                         status_hits[bdd_pkg::ST_ELEMENT]));
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/bdd_pkg.sv
src/bdd_req_if.sv
src/bdd_rsp_if.sv
src/bdd_ram.sv
src/bdd_front.sv
src/bdd_back.sv
src/bounded_deque_with_delete.sv
bench/testbench.sv
